>>> rtl/core/slsm_pkg.sv
// slsm_pkg: shared codes and types of the skip list sorted multiset
// command, status and lfsr constants, free stack control struct
// no dependencies
package slsm_pkg;

  localparam logic [1:0] CMD_SEARCH = 2'd0;
  localparam logic [1:0] CMD_ADD    = 2'd1;
  localparam logic [1:0] CMD_ERASE  = 2'd2;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [31:0] LFSR_SEED = 32'h1D87_2B41;
  localparam logic [31:0] LFSR_MASK = 32'h8020_0003;

  typedef struct packed {
    logic push;
    logic pop;
  } fs_ctrl_t;

endpackage

>>> rtl/core/slsm_link_mem.sv
// slsm_link_mem: synchronous link memory, one write and one read port
// registered read data, valid in the cycle after the read
// no dependencies
module slsm_link_mem #(
  parameter int unsigned ADDR_W = 15,
  parameter int unsigned DATA_W = 11
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [(2**ADDR_W)];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/slsm_free_stack.sv
// slsm_free_stack: free node stack in a synchronous memory with fill count
// entries below the low water mark were never written and read as their index
// depends on slsm_pkg
module slsm_free_stack #(
  parameter int unsigned CAPACITY = 1024,
  parameter int unsigned IDX_W    = 10,
  parameter int unsigned CNT_W    = 11
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  slsm_pkg::fs_ctrl_t  ctrl_i,
  input  logic [IDX_W-1:0]    push_node_i,
  output logic [IDX_W-1:0]    pop_node_o,
  output logic [CNT_W-1:0]    count_o
);

  localparam logic [CNT_W-1:0] Full = CNT_W'(CAPACITY);

  logic [IDX_W-1:0] mem [CAPACITY];
  logic [IDX_W-1:0] rdata_q;
  logic [IDX_W-1:0] idx_q;
  logic             sel_mem_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] low_q, low_d;
  logic [CNT_W-1:0] top_pos;

  assign top_pos = count_q - CNT_W'(1);

  always_comb begin
    count_d = count_q;
    low_d   = low_q;
    if (ctrl_i.pop && count_q != '0) begin
      count_d = top_pos;
      if (top_pos < low_q) begin
        low_d = top_pos;
      end
    end else if (ctrl_i.push && count_q != Full) begin
      count_d = count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= Full;
      low_q   <= Full;
    end else begin
      count_q <= count_d;
      low_q   <= low_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.pop) begin
      rdata_q   <= mem[top_pos[IDX_W-1:0]];
      idx_q     <= top_pos[IDX_W-1:0];
      sel_mem_q <= (top_pos >= low_q);
    end else if (ctrl_i.push && count_q != Full) begin
      mem[count_q[IDX_W-1:0]] <= push_node_i;
    end
  end

  assign pop_node_o = sel_mem_q ? rdata_q : idx_q;
  assign count_o    = count_q;

endmodule

>>> rtl/core/skip_list_sorted_multiset.sv
// skip_list_sorted_multiset: top level, operation sequencer and node value memory
// depends on slsm_pkg, slsm_link_mem, slsm_free_stack
//
// Input channel (in_valid_i / in_ready_o) carries one request: cmd_i (0 search,
// 1 add, 2 erase one copy) and the signed value_i. Output channel
// (out_valid_o / out_ready_i) returns one result per request: hit_o, status_o
// and stored_count_o, the number of values held after the request.
// Requests are handled one at a time. A request walks the skip list from the
// top level in use down to level 0; each link step is a link memory read, the
// link response and a node value read. An add then draws its height from the
// lfsr one bit a cycle, pops a node from the free stack and splices it in level
// by level, writing its own link and, unless the predecessor is the head, the
// predecessor's link; an erase unlinks the node level by level, then shrinks
// the top level past empty head links. A refused add (full pool) goes straight
// to the result.
// in_ready_o is high while the sequencer is idle; a finished result sits in
// the output register while the next request is accepted, and a stalled
// receiver holds the sequencer only when a second result is ready to load.
// Reset empties the set at once: head links are flip-flops, the free stack
// uses a fill mark, so no clearing pass is needed.
module skip_list_sorted_multiset #(
  parameter int unsigned CAPACITY  = 1024,
  parameter int unsigned MAX_LEVEL = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          cmd_i,
  input  logic signed [31:0]                  value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                hit_o,
  output logic [1:0]                          status_o,
  output logic [$clog2(CAPACITY+1)-1:0]       stored_count_o
);

  localparam int unsigned IDX_W  = $clog2(CAPACITY);
  localparam int unsigned LINK_W = $clog2(CAPACITY + 1);
  localparam int unsigned LEVELS = MAX_LEVEL + 1;
  localparam int unsigned LVL_W  = $clog2(MAX_LEVEL + 1);
  localparam int unsigned ADDR_W = IDX_W + LVL_W;
  localparam logic [LINK_W-1:0] Nil  = LINK_W'(CAPACITY);
  localparam logic [LINK_W-1:0] Head = LINK_W'(CAPACITY);
  localparam logic [LVL_W-1:0]  LvlMax = LVL_W'(MAX_LEVEL);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LREQ   = 4'd1;
  localparam logic [3:0] S_LRSP   = 4'd2;
  localparam logic [3:0] S_VRSP   = 4'd3;
  localparam logic [3:0] S_DECIDE = 4'd4;
  localparam logic [3:0] S_DRAW   = 4'd5;
  localparam logic [3:0] S_POP    = 4'd6;
  localparam logic [3:0] S_POPR   = 4'd7;
  localparam logic [3:0] S_LINKA  = 4'd8;
  localparam logic [3:0] S_LINKB  = 4'd9;
  localparam logic [3:0] S_EREQ   = 4'd10;
  localparam logic [3:0] S_ERSP   = 4'd11;
  localparam logic [3:0] S_SHRINK = 4'd12;
  localparam logic [3:0] S_DONE   = 4'd13;

  logic [3:0]               state_q, state_d;
  logic [1:0]               cmd_q, cmd_d;
  logic signed [31:0]       val_q, val_d;
  logic [LINK_W-1:0]        cur_q, cur_d;
  logic [LINK_W-1:0]        nx_q, nx_d;
  logic [LINK_W-1:0]        succ_q, succ_d;
  logic                     succ_eq_q, succ_eq_d;
  logic [LVL_W-1:0]         lvl_q, lvl_d;
  logic [LVL_W-1:0]         height_q, height_d;
  logic [LVL_W-1:0]         top_q, top_d;
  logic [IDX_W-1:0]         node_q, node_d;
  logic [31:0]              lfsr_q, lfsr_d;
  logic [LINK_W-1:0]        pred_q [LEVELS];
  logic [LINK_W-1:0]        pred_d [LEVELS];
  logic [LINK_W-1:0]        predn_q [LEVELS];
  logic [LINK_W-1:0]        predn_d [LEVELS];
  logic [LINK_W-1:0]        head_q [LEVELS];
  logic [LINK_W-1:0]        head_d [LEVELS];
  logic                     res_hit_q, res_hit_d;
  logic [1:0]               res_status_q, res_status_d;
  logic                     out_valid_q, out_valid_d;
  logic                     out_hit_q, out_hit_d;
  logic [1:0]               out_status_q, out_status_d;
  logic [LINK_W-1:0]        out_count_q, out_count_d;

  logic                     lm_we, lm_re;
  logic [ADDR_W-1:0]        lm_waddr, lm_raddr;
  logic [LINK_W-1:0]        lm_wdata, lm_rdata;

  logic                     vm_we, vm_re;
  logic [IDX_W-1:0]         vm_raddr;
  logic [31:0]              vm_rdata_q;
  logic [31:0]              vmem [CAPACITY];

  slsm_pkg::fs_ctrl_t       fs_ctrl;
  logic [IDX_W-1:0]         fs_push_node;
  logic [IDX_W-1:0]         fs_pop_node;
  logic [LINK_W-1:0]        fs_count;

  logic                     in_fire;
  logic [LINK_W-1:0]        nx_cur;
  logic                     brk;
  logic [LINK_W-1:0]        brk_nx;
  logic                     brk_eq;
  logic                     draw_bit;

  slsm_link_mem #(
    .ADDR_W (ADDR_W),
    .DATA_W (LINK_W)
  ) u_link_mem (
    .clk_i   (clk_i),
    .we_i    (lm_we),
    .waddr_i (lm_waddr),
    .wdata_i (lm_wdata),
    .re_i    (lm_re),
    .raddr_i (lm_raddr),
    .rdata_o (lm_rdata)
  );

  slsm_free_stack #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W),
    .CNT_W    (LINK_W)
  ) u_free_stack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (fs_ctrl),
    .push_node_i (fs_push_node),
    .pop_node_o  (fs_pop_node),
    .count_o     (fs_count)
  );

  always_ff @(posedge clk_i) begin
    if (vm_we) begin
      vmem[node_d] <= val_q;
    end
    if (vm_re) begin
      vm_rdata_q <= vmem[vm_raddr];
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign nx_cur     = (cur_q == Head) ? head_q[lvl_q] : lm_rdata;
  assign draw_bit   = lfsr_q[0];
  assign fs_push_node = succ_q[IDX_W-1:0];

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    val_d        = val_q;
    cur_d        = cur_q;
    nx_d         = nx_q;
    succ_d       = succ_q;
    succ_eq_d    = succ_eq_q;
    lvl_d        = lvl_q;
    height_d     = height_q;
    top_d        = top_q;
    node_d       = node_q;
    lfsr_d       = lfsr_q;
    pred_d       = pred_q;
    predn_d      = predn_q;
    head_d       = head_q;
    res_hit_d    = res_hit_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_hit_d    = out_hit_q;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;
    lm_we        = 1'b0;
    lm_re        = 1'b0;
    lm_waddr     = {cur_q[IDX_W-1:0], lvl_q};
    lm_raddr     = {cur_q[IDX_W-1:0], lvl_q};
    lm_wdata     = predn_q[lvl_q];
    vm_we        = 1'b0;
    vm_re        = 1'b0;
    vm_raddr     = nx_cur[IDX_W-1:0];
    fs_ctrl      = '0;
    brk          = 1'b0;
    brk_nx       = nx_cur;
    brk_eq       = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          cmd_d    = cmd_i;
          val_d    = value_i;
          cur_d    = Head;
          lvl_d    = top_q;
          height_d = '0;
          for (int i = 0; i < LEVELS; i++) begin
            pred_d[i]  = Head;
            predn_d[i] = Nil;
          end
          if (cmd_i == slsm_pkg::CMD_ADD && fs_count == '0) begin
            res_hit_d    = 1'b0;
            res_status_d = slsm_pkg::ST_FULL;
            state_d      = S_DONE;
          end else begin
            state_d = S_LREQ;
          end
        end
      end
      S_LREQ: begin
        lm_re   = (cur_q != Head);
        state_d = S_LRSP;
      end
      S_LRSP: begin
        nx_d = nx_cur;
        if (nx_cur >= Nil) begin
          brk    = 1'b1;
          brk_nx = nx_cur;
          brk_eq = 1'b0;
        end else begin
          vm_re   = 1'b1;
          state_d = S_VRSP;
        end
      end
      S_VRSP: begin
        if ($signed(vm_rdata_q) >= val_q) begin
          brk    = 1'b1;
          brk_nx = nx_q;
          brk_eq = ($signed(vm_rdata_q) == val_q);
        end else begin
          cur_d   = nx_q;
          state_d = S_LREQ;
        end
      end
      S_DECIDE: begin
        case (cmd_q)
          slsm_pkg::CMD_ADD: begin
            state_d = S_DRAW;
          end
          slsm_pkg::CMD_ERASE: begin
            if (!succ_eq_q) begin
              res_hit_d    = 1'b0;
              res_status_d = slsm_pkg::ST_MISS;
              state_d      = S_DONE;
            end else begin
              lvl_d   = '0;
              state_d = S_EREQ;
            end
          end
          default: begin
            res_hit_d    = succ_eq_q;
            res_status_d = succ_eq_q ? slsm_pkg::ST_DONE : slsm_pkg::ST_MISS;
            state_d      = S_DONE;
          end
        endcase
      end
      S_DRAW: begin
        lfsr_d = (lfsr_q >> 1) ^ (draw_bit ? slsm_pkg::LFSR_MASK : 32'd0);
        if (draw_bit && height_q < LvlMax) begin
          height_d = height_q + LVL_W'(1);
        end else begin
          if (height_q > top_q) begin
            top_d = height_q;
          end
          state_d = S_POP;
        end
      end
      S_POP: begin
        fs_ctrl.pop = 1'b1;
        state_d     = S_POPR;
      end
      S_POPR: begin
        node_d  = fs_pop_node;
        vm_we   = 1'b1;
        lvl_d   = '0;
        state_d = S_LINKA;
      end
      S_LINKA: begin
        lm_we    = 1'b1;
        lm_waddr = {node_q, lvl_q};
        lm_wdata = predn_q[lvl_q];
        if (pred_q[lvl_q] == Head) begin
          head_d[lvl_q] = LINK_W'(node_q);
          if (lvl_q == height_q) begin
            res_hit_d    = 1'b1;
            res_status_d = slsm_pkg::ST_DONE;
            state_d      = S_DONE;
          end else begin
            lvl_d = lvl_q + LVL_W'(1);
          end
        end else begin
          state_d = S_LINKB;
        end
      end
      S_LINKB: begin
        lm_we    = 1'b1;
        lm_waddr = {pred_q[lvl_q][IDX_W-1:0], lvl_q};
        lm_wdata = LINK_W'(node_q);
        if (lvl_q == height_q) begin
          res_hit_d    = 1'b1;
          res_status_d = slsm_pkg::ST_DONE;
          state_d      = S_DONE;
        end else begin
          lvl_d   = lvl_q + LVL_W'(1);
          state_d = S_LINKA;
        end
      end
      S_EREQ: begin
        if (predn_q[lvl_q] != succ_q) begin
          fs_ctrl.push = 1'b1;
          state_d      = S_SHRINK;
        end else begin
          lm_re    = 1'b1;
          lm_raddr = {succ_q[IDX_W-1:0], lvl_q};
          state_d  = S_ERSP;
        end
      end
      S_ERSP: begin
        if (pred_q[lvl_q] == Head) begin
          head_d[lvl_q] = lm_rdata;
        end else begin
          lm_we    = 1'b1;
          lm_waddr = {pred_q[lvl_q][IDX_W-1:0], lvl_q};
          lm_wdata = lm_rdata;
        end
        if (lvl_q == top_q) begin
          fs_ctrl.push = 1'b1;
          state_d      = S_SHRINK;
        end else begin
          lvl_d   = lvl_q + LVL_W'(1);
          state_d = S_EREQ;
        end
      end
      S_SHRINK: begin
        if (top_q != '0 && head_q[top_q] == Nil) begin
          top_d = top_q - LVL_W'(1);
        end else begin
          res_hit_d    = 1'b1;
          res_status_d = slsm_pkg::ST_DONE;
          state_d      = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_hit_d    = res_hit_q;
          out_status_d = res_status_q;
          out_count_d  = LINK_W'(CAPACITY) - fs_count;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (brk) begin
      pred_d[lvl_q]  = cur_q;
      predn_d[lvl_q] = brk_nx;
      if (lvl_q == '0) begin
        succ_d    = brk_nx;
        succ_eq_d = brk_eq;
        state_d   = S_DECIDE;
      end else begin
        lvl_d   = lvl_q - LVL_W'(1);
        state_d = S_LREQ;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      top_q       <= '0;
      lfsr_q      <= slsm_pkg::LFSR_SEED;
      out_valid_q <= 1'b0;
      for (int i = 0; i < LEVELS; i++) begin
        head_q[i] <= Nil;
      end
    end else begin
      state_q     <= state_d;
      top_q       <= top_d;
      lfsr_q      <= lfsr_d;
      out_valid_q <= out_valid_d;
      head_q      <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    val_q        <= val_d;
    cur_q        <= cur_d;
    nx_q         <= nx_d;
    succ_q       <= succ_d;
    succ_eq_q    <= succ_eq_d;
    lvl_q        <= lvl_d;
    height_q     <= height_d;
    node_q       <= node_d;
    pred_q       <= pred_d;
    predn_q      <= predn_d;
    res_hit_q    <= res_hit_d;
    res_status_q <= res_status_d;
    out_hit_q    <= out_hit_d;
    out_status_q <= out_status_d;
    out_count_q  <= out_count_d;
  end

  assign out_valid_o    = out_valid_q;
  assign hit_o          = out_hit_q;
  assign status_o       = out_status_q;
  assign stored_count_o = out_count_q;

  a_top_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_q <= LvlMax)
    else $error("top level above maximum");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fs_count <= LINK_W'(CAPACITY))
    else $error("free count above capacity");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("request accepted while busy");

  a_full_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && cmd_i == slsm_pkg::CMD_ADD && fs_count == '0) |=> state_q == S_DONE)
    else $error("add into full pool not refused");

endmodule

>>> tb/sv/tb.sv
// tb: self-checking testbench for skip_list_sorted_multiset
// predicts each result with a behavioral multiset plus the height lfsr
// depends on slsm_pkg and the rtl of skip_list_sorted_multiset
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CAP = 1024;
  localparam int unsigned MAXLVL = 16;
  localparam int unsigned CNT_W = $clog2(CAP + 1);
  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam logic [1:0] CMD_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] value;
  } request_t;

  typedef struct packed {
    logic             hit;
    logic [1:0]       status;
    logic [CNT_W-1:0] count;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] cmd_i = slsm_pkg::CMD_SEARCH;
  logic signed [31:0] value_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic hit_o;
  logic [1:0] status_o;
  logic [CNT_W-1:0] stored_count_o;

  skip_list_sorted_multiset dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .cmd_i, .value_i,
    .out_valid_o, .out_ready_i, .hit_o, .status_o, .stored_count_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // multiset contents: value -> copies; only counts matter to the outputs
  int unsigned copies [logic [31:0]];
  int unsigned held;
  logic [31:0] lfsr;

  request_t pending_reqs[$];
  answer_t  expected_answers[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned accepted = 0;
  int unsigned total_reqs = 0;
  bit hold_off = 1'b0;
  logic [31:0] pool[$];

  function automatic logic take_bit();
    logic b;
    b = lfsr[0];
    lfsr = lfsr >> 1;
    if (b) lfsr = lfsr ^ slsm_pkg::LFSR_MASK;
    return b;
  endfunction

  function automatic answer_t predict_answer(request_t r);
    answer_t a;
    int unsigned lvl;
    logic b;
    a = '0;
    if (r.cmd == slsm_pkg::CMD_ADD) begin
      if (held == CAP) begin
        a.status = slsm_pkg::ST_FULL;
      end else begin
        lvl = 0;
        b = take_bit();
        while (b && lvl < MAXLVL) begin
          b = take_bit();
          lvl++;
        end
        if (copies.exists(r.value)) copies[r.value]++;
        else copies[r.value] = 1;
        held++;
        a.hit = 1'b1;
        a.status = slsm_pkg::ST_DONE;
      end
    end else if (r.cmd == slsm_pkg::CMD_ERASE) begin
      if (copies.exists(r.value) && copies[r.value] > 0) begin
        copies[r.value]--;
        held--;
        a.hit = 1'b1;
        a.status = slsm_pkg::ST_DONE;
      end else begin
        a.status = slsm_pkg::ST_MISS;
      end
    end else begin
      if (copies.exists(r.value) && copies[r.value] > 0) begin
        a.hit = 1'b1;
        a.status = slsm_pkg::ST_DONE;
      end else begin
        a.status = slsm_pkg::ST_MISS;
      end
    end
    a.count = held[CNT_W-1:0];
    return a;
  endfunction

  function automatic logic [31:0] pick_value();
    int unsigned k;
    k = $urandom_range(0, 9);
    if (pool.size() > 0 && k < 6) return pool[$urandom_range(0, pool.size() - 1)];
    if (k == 6) return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    return $urandom;
  endfunction

  task automatic queue_req(logic [1:0] c, logic [31:0] v);
    request_t r;
    r.cmd = c;
    r.value = v;
    pending_reqs.push_back(r);
    total_reqs++;
    if (c == slsm_pkg::CMD_ADD && pool.size() < 64) pool.push_back(v);
  endtask

  // driver
  int unsigned send_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_answers.push_back(predict_answer(pending_reqs.pop_front()));
        accepted++;
        send_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      end
      if (!(in_valid_i && !in_ready_o)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_reqs.size() > 0 &&
                     !(in_valid_i && in_ready_o && pending_reqs.size() == 0)) begin
          in_valid_i <= 1'b1;
          cmd_i <= pending_reqs[0].cmd;
          value_i <= pending_reqs[0].value;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  int unsigned recv_gap = 0;
  answer_t exp_a;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_answers.size() == 0) begin
          $error("result with no request outstanding");
          errors++;
        end else begin
          exp_a = expected_answers.pop_front();
          if (hit_o !== exp_a.hit) begin
            $error("hit expected %0d actual %0d", exp_a.hit, hit_o);
            errors++;
          end
          if (status_o !== exp_a.status) begin
            $error("status expected %0d actual %0d", exp_a.status, status_o);
            errors++;
          end
          if (stored_count_o !== exp_a.count) begin
            $error("stored_count expected %0d actual %0d", exp_a.count, stored_count_o);
            errors++;
          end
        end
        recv_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      end
      if (hold_off) begin
        out_ready_i <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // long receiver stall, counted here
  initial begin
    wait (accepted >= 100);
    @(posedge clk_i);
    hold_off = 1'b1;
    repeat (400) @(posedge clk_i);
    hold_off = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    int unsigned n;
    int unsigned k;
    logic [31:0] v;
    held = 0;
    lfsr = slsm_pkg::LFSR_SEED;

    // directed: misses on empty, extremes, duplicates, unused command
    queue_req(slsm_pkg::CMD_SEARCH, 32'h8000_0000);
    queue_req(slsm_pkg::CMD_ERASE, 32'h7FFF_FFFF);
    queue_req(slsm_pkg::CMD_ADD, 32'h8000_0000);
    queue_req(slsm_pkg::CMD_ADD, 32'h7FFF_FFFF);
    queue_req(slsm_pkg::CMD_ADD, 32'h0000_0000);
    queue_req(slsm_pkg::CMD_ADD, 32'hFFFF_FFFF);
    queue_req(slsm_pkg::CMD_ADD, 32'h0000_0000);
    queue_req(slsm_pkg::CMD_SEARCH, 32'h0000_0000);
    queue_req(slsm_pkg::CMD_SEARCH, 32'h0000_0001);
    queue_req(CMD_SPARE, 32'h7FFF_FFFF);
    queue_req(CMD_SPARE, 32'h1234_5678);
    queue_req(slsm_pkg::CMD_ERASE, 32'h0000_0000);
    queue_req(slsm_pkg::CMD_SEARCH, 32'h0000_0000);
    queue_req(slsm_pkg::CMD_ERASE, 32'h0000_0000);
    queue_req(slsm_pkg::CMD_SEARCH, 32'h0000_0000);
    queue_req(slsm_pkg::CMD_ERASE, 32'h8000_0000);
    queue_req(slsm_pkg::CMD_ERASE, 32'hFFFF_FFFF);
    queue_req(slsm_pkg::CMD_SEARCH, 32'h7FFF_FFFF);
    queue_req(slsm_pkg::CMD_ERASE, 32'h7FFF_FFFF);

    // random mix
    for (n = 0; n < 480; n++) begin
      k = $urandom_range(0, 9);
      v = pick_value();
      if (k < 4) queue_req(slsm_pkg::CMD_ADD, v);
      else if (k < 7) queue_req(slsm_pkg::CMD_ERASE, v);
      else if (k < 9) queue_req(slsm_pkg::CMD_SEARCH, v);
      else queue_req(CMD_SPARE, v);
    end
    // bulk adds with repeats, then drain
    for (n = 0; n < 300; n++) begin
      queue_req(slsm_pkg::CMD_ADD, $urandom_range(0, 15) == 0 ? 32'd5 : $urandom);
    end
    for (n = 0; n < 6; n++) queue_req(slsm_pkg::CMD_SEARCH, pick_value());
    for (n = 0; n < 100; n++) begin
      queue_req($urandom_range(0, 3) == 0 ? slsm_pkg::CMD_SEARCH : slsm_pkg::CMD_ERASE,
                pick_value());
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (accepted == total_reqs && expected_answers.size() == 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && expected_answers.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/slsm_pkg.sv
rtl/core/slsm_link_mem.sv
rtl/core/slsm_free_stack.sv
rtl/core/skip_list_sorted_multiset.sv
tb/sv/tb.sv
